// ===== rtl/olir_pkg.sv =====
// Shared constants, command codes and cell control type for the ordered list engine.
package olir_pkg;

    localparam int OLIR_CAPACITY = 64;
    localparam int DATA_W        = 32;
    localparam int KIND_W        = 3;
    localparam int INDEX_W       = 6;
    localparam int LEN_W         = 7;
    localparam int STAT_W        = 2;

    typedef enum logic [KIND_W-1:0] {
        K_APPEND    = 3'd0,
        K_DROP      = 3'd1,
        K_INSERT    = 3'd2,
        K_REMOVE    = 3'd3,
        K_READ      = 3'd4,
        K_OVERWRITE = 3'd5,
        K_CLEAR     = 3'd6
    } kind_t;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Broadcast to every cell: load the command value at the target position,
    // take the lower neighbor above it, or take the upper neighbor from it on.
    typedef struct packed {
        logic wr;
        logic up;
        logic dn;
    } cell_ctl_t;

endpackage

// ===== rtl/olir_cell.sv =====
// One list position: holds an entry and loads it from the command or a neighbor.
module olir_cell
    import olir_pkg::*;
#(
    parameter int PW  = 7,
    parameter int POS = 0
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [PW-1:0]     pos,
    input  logic [DATA_W-1:0] value,
    input  logic [DATA_W-1:0] left,
    input  logic [DATA_W-1:0] right,
    output logic [DATA_W-1:0] data
);

    localparam logic [PW-1:0] MY_POS = PW'(POS);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.wr && (pos == MY_POS))
        begin
            data_next = value;
        end
        else if (ctl.up && (MY_POS > pos))
        begin
            data_next = left;
        end
        else if (ctl.dn && (MY_POS >= pos))
        begin
            data_next = right;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/ordered_list_insert_remove.sv =====
// Ordered list engine: a row of CAPACITY entry cells with a length counter. Each
// command (append, drop last, insert at, remove at, read, overwrite, clear) is
// decoded in the cycle it is accepted on the cmd channel and completes in that
// same cycle: every cell loads the new value, its lower or its upper neighbor, or
// holds, all in parallel, so an insert or remove moves the whole tail at once.
// One command per cycle is sustained while responses drain; the response word (read
// value, length after the command, status) is held in an output register from the
// cycle after acceptance, and a new command is taken whenever that register is empty
// or being drained. The cell row needs no clearing after reset: entries at or above
// the length are never read. A read out of range returns -1 with status 1; full and
// empty conditions leave the list unchanged and report status 2 and 3.
module ordered_list_insert_remove
    import olir_pkg::*;
#(
    parameter int CAPACITY = OLIR_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_ready,
    input  logic [KIND_W-1:0]        kind,
    input  logic [INDEX_W-1:0]       index,
    input  logic signed [DATA_W-1:0] value,
    output logic                     rsp_valid,
    input  logic                     rsp_ready,
    output logic signed [DATA_W-1:0] read_value,
    output logic [LEN_W-1:0]         length,
    output logic [STAT_W-1:0]        status
);

    // Count width holds CAPACITY itself; compares run at the wider of count and index.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > INDEX_W) ? CW : INDEX_W;

    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic              rsp_valid_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic              accept;
    logic [LW-1:0]     idx_ext;
    logic [LW-1:0]     cnt_ext;
    logic              full;
    cell_ctl_t         ctl_raw;
    cell_ctl_t         ctl;
    logic [CW-1:0]     pos;
    logic [DATA_W-1:0] sel;
    logic [DATA_W-1:0] cell_data [CAPACITY];

    // Take a new word whenever the response register is free or draining.
    assign cmd_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = cmd_valid && cmd_ready;

    assign idx_ext = LW'(index);
    assign cnt_ext = LW'(count_reg);
    assign full    = (count_reg == CW'(CAPACITY));

    // Pick the addressed entry out of the row for a read.
    always_comb
    begin
        sel = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            sel = sel | (cell_data[i] & {DATA_W{idx_ext == LW'(i)}});
        end
    end

    // Decode the command against the current length.
    always_comb
    begin
        ctl_raw         = '0;
        pos             = CW'(idx_ext);
        count_next      = count_reg;
        read_value_next = '0;
        status_next     = ST_OK;
        case (kind_t'(kind))
            K_APPEND:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    ctl_raw.wr = 1'b1;
                    pos        = count_reg;
                    count_next = count_reg + CW'(1);
                end
            end
            K_DROP:
            begin
                if (count_reg == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            K_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else if (idx_ext > cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctl_raw.wr = 1'b1;
                    ctl_raw.up = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            K_REMOVE:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctl_raw.dn = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            K_READ:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    status_next     = ST_RANGE;
                    read_value_next = '1;
                end
                else
                begin
                    read_value_next = sel;
                end
            end
            K_OVERWRITE:
            begin
                if (idx_ext >= cnt_ext)
                begin
                    status_next = ST_RANGE;
                end
                else
                begin
                    ctl_raw.wr = 1'b1;
                end
            end
            K_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Cells move only on an accepted word.
    assign ctl = accept ? ctl_raw : '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] left_in;
            logic [DATA_W-1:0] right_in;
            if (g == 0)
            begin : g_first
                assign left_in = value;
            end
            else
            begin : g_mid
                assign left_in = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_in = cell_data[g];
            end
            else
            begin : g_inner
                assign right_in = cell_data[g+1];
            end
            olir_cell #(
                .PW  (CW),
                .POS (g)
            ) u_cell (
                .clk   (clk),
                .ctl   (ctl),
                .pos   (pos),
                .value (value),
                .left  (left_in),
                .right (right_in),
                .data  (cell_data[g])
            );
        end
    endgenerate

    // Hold length and response control; advance on accept, drop valid when drained.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_value_reg <= read_value_next;
            status_reg     <= status_next;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    // Length only changes together with a new response word, so show the counter.
    assign length     = LEN_W'(count_reg);

    // The length never passes the depth of the cell row.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
    else $error("list length beyond capacity");

    // Every accepted word yields a response in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid)
    else $error("accepted word produced no response");

    // A full report only comes with a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (status == ST_FULL)) |-> (count_reg == CW'(CAPACITY)))
    else $error("full status with room left");

    // An accepted clear empties the list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (kind == K_CLEAR)) |=> (count_reg == '0))
    else $error("clear left entries behind");

endmodule
